// ===== rtl/core/one_wire_master_byte_engine_macros.svh =====
// assertion macros shared by the one-wire master engine modules
`ifndef ONE_WIRE_MASTER_BYTE_ENGINE_MACROS_SVH
`define ONE_WIRE_MASTER_BYTE_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define OWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("one-wire engine check failed");

// next-cycle implication, disabled during reset
`define OWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("one-wire engine check failed");

`endif

// ===== rtl/core/owm_pkg.sv =====
// types, codes and register defaults of the one-wire master byte engine
package owm_pkg;

   localparam int REG_WIDTH           = 10;
   localparam int CSR_ADDR_WIDTH      = 3;
   localparam int COUNT_WIDTH_DEFAULT = 10;

   // command codes
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_PRESENCE_DLY  = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RESET_RECOV   = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_WRITE_START   = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_WRITE_HOLD    = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_WRITE_RECOVER = 3'd5;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_READ_START    = 3'd6;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_READ_WAIT     = 3'd7;

   // register reset values
   localparam logic [REG_WIDTH-1:0] RESET_LOW_DEFAULT     = 10'd480;
   localparam logic [REG_WIDTH-1:0] PRESENCE_DLY_DEFAULT  = 10'd60;
   localparam logic [REG_WIDTH-1:0] RESET_RECOV_DEFAULT   = 10'd500;
   localparam logic [REG_WIDTH-1:0] WRITE_START_DEFAULT   = 10'd5;
   localparam logic [REG_WIDTH-1:0] WRITE_HOLD_DEFAULT    = 10'd65;
   localparam logic [REG_WIDTH-1:0] WRITE_RECOVER_DEFAULT = 10'd2;
   localparam logic [REG_WIDTH-1:0] READ_START_DEFAULT    = 10'd10;
   localparam logic [REG_WIDTH-1:0] READ_WAIT_DEFAULT     = 10'd45;

   typedef struct packed {
      logic [REG_WIDTH-1:0] reset_low_time;
      logic [REG_WIDTH-1:0] presence_delay;
      logic [REG_WIDTH-1:0] reset_recovery;
      logic [REG_WIDTH-1:0] write_start_time;
      logic [REG_WIDTH-1:0] write_hold_time;
      logic [REG_WIDTH-1:0] write_recover_time;
      logic [REG_WIDTH-1:0] read_start_time;
      logic [REG_WIDTH-1:0] read_wait_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] tx_byte;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       drive_low;
   } result_type;

   typedef enum logic [9:0] {
      PH_IDLE      = 10'b00_0000_0001,
      PH_RST_LOW   = 10'b00_0000_0010,
      PH_RST_WAIT  = 10'b00_0000_0100,
      PH_RST_WATCH = 10'b00_0000_1000,
      PH_RST_RECOV = 10'b00_0001_0000,
      PH_WR_START  = 10'b00_0010_0000,
      PH_WR_HOLD   = 10'b00_0100_0000,
      PH_WR_REC    = 10'b00_1000_0000,
      PH_RD_START  = 10'b01_0000_0000,
      PH_RD_WAIT   = 10'b10_0000_0000
   } phase_type;

endpackage

// ===== rtl/core/owm_csr.sv =====
// timing register file of the one-wire master engine
module owm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [owm_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [owm_pkg::REG_WIDTH-1:0]         csr_wdata,
   output owm_pkg::cfg_type                      cfg
);

   owm_pkg::cfg_type cfg_ff;
   owm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            owm_pkg::REG_RESET_LOW:     cfg_in.reset_low_time     = csr_wdata;
            owm_pkg::REG_PRESENCE_DLY:  cfg_in.presence_delay     = csr_wdata;
            owm_pkg::REG_RESET_RECOV:   cfg_in.reset_recovery     = csr_wdata;
            owm_pkg::REG_WRITE_START:   cfg_in.write_start_time   = csr_wdata;
            owm_pkg::REG_WRITE_HOLD:    cfg_in.write_hold_time    = csr_wdata;
            owm_pkg::REG_WRITE_RECOVER: cfg_in.write_recover_time = csr_wdata;
            owm_pkg::REG_READ_START:    cfg_in.read_start_time    = csr_wdata;
            owm_pkg::REG_READ_WAIT:     cfg_in.read_wait_time     = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time     <= owm_pkg::RESET_LOW_DEFAULT;
         cfg_ff.presence_delay     <= owm_pkg::PRESENCE_DLY_DEFAULT;
         cfg_ff.reset_recovery     <= owm_pkg::RESET_RECOV_DEFAULT;
         cfg_ff.write_start_time   <= owm_pkg::WRITE_START_DEFAULT;
         cfg_ff.write_hold_time    <= owm_pkg::WRITE_HOLD_DEFAULT;
         cfg_ff.write_recover_time <= owm_pkg::WRITE_RECOVER_DEFAULT;
         cfg_ff.read_start_time    <= owm_pkg::READ_START_DEFAULT;
         cfg_ff.read_wait_time     <= owm_pkg::READ_WAIT_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/owm_core.sv =====
// slot sequencer of the one-wire master: advances one tick per step
`include "one_wire_master_byte_engine_macros.svh"

module owm_core #(
   parameter int COUNT_WIDTH = owm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  owm_pkg::item_type      item,
   input  owm_pkg::cfg_type       cfg,
   output owm_pkg::result_type    res
);

   localparam int CntExt = COUNT_WIDTH + 1;
   localparam logic [CntExt-1:0] Lim = CntExt'(1) << COUNT_WIDTH;

   owm_pkg::phase_type       phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]   tick_ff, tick_in;
   logic [2:0]               bit_ff, bit_in;
   logic [7:0]               shift_ff, shift_in;
   logic                     mode_rd_ff, mode_rd_in;

   // last tick of a phase: zero acts as one, long values clamp to the counter range
   function automatic logic phase_ends(input logic [owm_pkg::REG_WIDTH-1:0] dur,
                                       input logic [COUNT_WIDTH-1:0] tick);
      logic [CntExt-1:0] d;
      logic [CntExt-1:0] nxt;
      d = CntExt'(dur);
      if (d == '0) d = CntExt'(1);
      if (d > Lim) d = Lim;
      nxt = CntExt'(tick) + CntExt'(1);
      return nxt >= d;
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      mode_rd_in = mode_rd_ff;
      res        = '0;

      if (phase_in == owm_pkg::PH_IDLE && item.cmd != owm_pkg::CMD_NONE) begin
         tick_in = '0;
         bit_in  = '0;
         case (item.cmd)
            owm_pkg::CMD_RESET: begin
               phase_in   = owm_pkg::PH_RST_LOW;
               mode_rd_in = 1'b0;
            end
            owm_pkg::CMD_WRITE: begin
               phase_in   = owm_pkg::PH_WR_START;
               mode_rd_in = 1'b0;
               shift_in   = item.tx_byte;
            end
            default: begin
               phase_in   = owm_pkg::PH_RD_START;
               mode_rd_in = 1'b1;
               shift_in   = '0;
            end
         endcase
      end

      res.busy_res = (phase_in != owm_pkg::PH_IDLE);

      case (phase_in)
         owm_pkg::PH_IDLE: begin
            phase_in = owm_pkg::PH_IDLE;
         end
         owm_pkg::PH_RST_LOW: begin
            res.drive_low = 1'b1;
            if (phase_ends(cfg.reset_low_time, tick_in)) begin
               tick_in  = '0;
               phase_in = owm_pkg::PH_RST_WAIT;
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         owm_pkg::PH_RST_WAIT: begin
            if (phase_ends(cfg.presence_delay, tick_in)) begin
               tick_in  = '0;
               phase_in = owm_pkg::PH_RST_WATCH;
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         owm_pkg::PH_RST_WATCH: begin
            // no timeout on the presence pulse
            if (!item.line_level) begin
               tick_in  = '0;
               phase_in = owm_pkg::PH_RST_RECOV;
            end
         end
         owm_pkg::PH_RST_RECOV: begin
            if (phase_ends(cfg.reset_recovery, tick_in)) begin
               tick_in      = '0;
               phase_in     = owm_pkg::PH_IDLE;
               res.done_res = 1'b1;
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         owm_pkg::PH_WR_START: begin
            res.drive_low = 1'b1;
            if (phase_ends(cfg.write_start_time, tick_in)) begin
               tick_in  = '0;
               phase_in = owm_pkg::PH_WR_HOLD;
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         owm_pkg::PH_WR_HOLD: begin
            res.drive_low = ~shift_in[0];
            if (phase_ends(cfg.write_hold_time, tick_in)) begin
               tick_in  = '0;
               phase_in = owm_pkg::PH_WR_REC;
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         owm_pkg::PH_WR_REC: begin
            if (phase_ends(cfg.write_recover_time, tick_in)) begin
               tick_in  = '0;
               shift_in = {1'b0, shift_in[7:1]};
               if (bit_in == 3'd7) begin
                  phase_in     = owm_pkg::PH_IDLE;
                  res.done_res = 1'b1;
                  bit_in       = '0;
               end else begin
                  bit_in   = bit_in + 3'd1;
                  phase_in = owm_pkg::PH_WR_START;
               end
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         owm_pkg::PH_RD_START: begin
            res.drive_low = 1'b1;
            if (phase_ends(cfg.read_start_time, tick_in)) begin
               tick_in  = '0;
               phase_in = owm_pkg::PH_RD_WAIT;
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         owm_pkg::PH_RD_WAIT: begin
            // sample on the first released tick
            if (tick_in == '0) begin
               shift_in = {item.line_level, shift_in[7:1]};
            end
            if (phase_ends(cfg.read_wait_time, tick_in)) begin
               tick_in = '0;
               if (bit_in == 3'd7) begin
                  phase_in     = owm_pkg::PH_IDLE;
                  res.done_res = 1'b1;
                  bit_in       = '0;
               end else begin
                  bit_in   = bit_in + 3'd1;
                  phase_in = owm_pkg::PH_RD_START;
               end
            end else begin
               tick_in = tick_in + COUNT_WIDTH'(1);
            end
         end
         default: begin
            phase_in = owm_pkg::PH_IDLE;
         end
      endcase

      if (res.done_res && mode_rd_in) begin
         res.rx_byte = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= owm_pkg::PH_IDLE;
         tick_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         mode_rd_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         mode_rd_ff <= mode_rd_in;
      end
   end

   `OWM_ASSERT_NEXT(a_done_goes_idle, clock, reset, step_en && res.done_res,
                    phase_ff == owm_pkg::PH_IDLE)
   `OWM_ASSERT_NOW(a_drive_only_busy, clock, reset, res.drive_low, res.busy_res)
   `OWM_ASSERT_NOW(a_idle_bit_clear, clock, reset, phase_ff == owm_pkg::PH_IDLE, bit_ff == 3'd0)
   `OWM_ASSERT_NEXT(a_no_cmd_stays_idle, clock, reset,
                    step_en && phase_ff == owm_pkg::PH_IDLE && item.cmd == owm_pkg::CMD_NONE,
                    phase_ff == owm_pkg::PH_IDLE)

endmodule

// ===== rtl/core/one_wire_master_byte_engine.sv =====
// One-wire bus master byte engine. Each req transfer is one timing tick (normally one
// microsecond) that carries the sampled line level and, while the engine is idle, a
// command: bus reset, write byte (LSB first) or read byte (LSB first); commands sent
// while busy are ignored. Every tick yields exactly one rsp transfer with drive_low,
// busy, done and the received byte (nonzero only on the done tick of a read). One
// tick is taken per clock cycle while the result register is free or draining; a tick is
// held in the input register and its result in the result register. Timing registers
// must be written through the csr port only while idle, by the user; the block does not enforce it.
`include "one_wire_master_byte_engine_macros.svh"

module one_wire_master_byte_engine #(
   parameter int COUNT_WIDTH = owm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [15:0]                           req_tdata,  // tx_byte, line_level, zero pad
   input  logic [1:0]                            req_tuser,  // cmd
   // rsp channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,  // drive_low, busy_res, done_res,
                                                             // rx_byte, zero pad
   // configuration writes
   input  logic                                  csr_we,
   input  logic [owm_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [owm_pkg::REG_WIDTH-1:0]         csr_wdata
);

   owm_pkg::cfg_type      cfg;
   owm_pkg::item_type     item_ff, item_in;
   owm_pkg::result_type   res;
   owm_pkg::result_type   out_ff;
   logic                  in_vld_ff, in_vld_in;
   logic                  out_vld_ff, out_vld_in;
   logic                  advance;

   owm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owm_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // a held tick moves on whenever the result register is free or draining
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      item_in.cmd        = req_tuser;
      item_in.tx_byte    = req_tdata[7:0];
      item_in.line_level = req_tdata[8];
      in_vld_in          = req_tvalid || (in_vld_ff && !advance);
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= in_vld_in;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_ff.rx_byte, out_ff.done_res, out_ff.busy_res,
                        out_ff.drive_low};

   `OWM_ASSERT_NOW(a_done_implies_busy, clock, reset, out_vld_ff && out_ff.done_res, out_ff.busy_res)
   `OWM_ASSERT_NOW(a_rx_only_on_done, clock, reset, out_vld_ff && out_ff.rx_byte != 8'd0, out_ff.done_res)
   `OWM_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_vld_ff)
   `OWM_ASSERT_NOW(a_stall_holds_item, clock, reset, !req_tready, in_vld_ff && out_vld_ff)

endmodule
